// ===== rtl/core/ifp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg: shared types and constants of the IMU frame parser
// Frame layout constants, the raw frame word type and the saturating negate.
// ----------------------------------------------------------------------------
package ifp_pkg;

  // Frame layout.
  localparam logic [7:0] HDR_BYTE       = 8'hA6;
  localparam int         PAYLOAD_LEN    = 18;
  localparam int         RESERVED_BYTES = 4;
  localparam int         NUM_WORDS      = PAYLOAD_LEN / 2;
  localparam int         CNT_W          = $clog2(PAYLOAD_LEN + 1);
  localparam int         IDX_W          = $clog2(PAYLOAD_LEN);
  localparam int         SKIP_W         = 4;

  // Word positions inside a frame.
  localparam int W_ROLL  = 0;
  localparam int W_PITCH = 1;
  localparam int W_YAW   = 2;
  localparam int W_RX    = 3;
  localparam int W_RY    = 4;
  localparam int W_RZ    = 5;
  localparam int W_AX    = 6;
  localparam int W_AY    = 7;
  localparam int W_AZ    = 8;

  // Nine raw little-endian words of one good frame.
  typedef logic [NUM_WORDS-1:0][15:0] raw_frame_t;

  // One result after the axis remap.
  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [15:0] turn_rate_x;
    logic signed [15:0] turn_rate_y;
    logic signed [15:0] turn_rate_z;
    logic signed [15:0] lin_accel_x;
    logic signed [15:0] lin_accel_y;
    logic signed [15:0] lin_accel_z;
  } imu_sample_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // Two's complement negate; the most negative value saturates.
  function automatic logic [15:0] neg_sat(input logic [15:0] v);
    logic [15:0] r;
    if (v == 16'h8000) begin
      r = 16'h7FFF;
    end else begin
      r = ~v + 16'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ifp_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_byte_if: byte stream channel
// Valid/ready channel carrying one raw sensor byte per transfer.
// ----------------------------------------------------------------------------
interface ifp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/core/ifp_imu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_imu_if: decoded sample channel
// Valid/ready channel carrying nine signed 16-bit values per transfer.
// ----------------------------------------------------------------------------
interface ifp_imu_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [15:0] turn_rate_x;
  logic signed [15:0] turn_rate_y;
  logic signed [15:0] turn_rate_z;
  logic signed [15:0] lin_accel_x;
  logic signed [15:0] lin_accel_y;
  logic signed [15:0] lin_accel_z;

  modport source (output valid, input ready,
                  output angle_x, output angle_y, output angle_z,
                  output turn_rate_x, output turn_rate_y, output turn_rate_z,
                  output lin_accel_x, output lin_accel_y, output lin_accel_z);
  modport sink   (input valid, output ready,
                  input angle_x, input angle_y, input angle_z,
                  input turn_rate_x, input turn_rate_y, input turn_rate_z,
                  input lin_accel_x, input lin_accel_y, input lin_accel_z);
endinterface

// ===== rtl/core/ifp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front: frame sync and checksum
// Tracks the frame phase byte by byte, collects the payload and pushes a
// raw frame into the queue when the checksum matches.
// ----------------------------------------------------------------------------
module ifp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output ifp_pkg::raw_frame_t q_data
);
  import ifp_pkg::*;

  typedef enum logic [2:0] {
    ST_HDR1,
    ST_HDR2,
    ST_INDEX,
    ST_DATA,
    ST_SKIP,
    ST_CHECK
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [SKIP_W-1:0] skip_r;
  logic [SKIP_W-1:0] skip_nxt;
  logic [7:0]        sum_r;
  logic [7:0]        sum_nxt;
  logic [7:0]        store_r [PAYLOAD_LEN];
  logic              take;

  // Only the checksum byte needs room in the queue.
  assign in_ready = (state_r != ST_CHECK) || !q_full;
  assign take     = in_valid && in_ready;
  assign sum_nxt  = sum_r + in_byte;
  assign skip_nxt = skip_r + SKIP_W'(1);
  assign q_push   = take && (state_r == ST_CHECK) && (in_byte == sum_r);

  // Pack the stored payload into little-endian words.
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      q_data[k] = {store_r[2*k+1], store_r[2*k]};
    end
  end

  // Phase machine with counters, checksum and payload store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR1;
      count_r <= '0;
      skip_r  <= '0;
      sum_r   <= '0;
    end else if (take) begin
      unique case (state_r)
        ST_HDR1: begin
          if (in_byte == HDR_BYTE) begin
            state_r <= ST_HDR2;
          end
        end
        ST_HDR2: begin
          if (in_byte == HDR_BYTE) begin
            state_r <= ST_INDEX;
          end else begin
            state_r <= ST_HDR1;
          end
        end
        ST_INDEX: begin
          sum_r   <= sum_nxt;
          state_r <= ST_DATA;
        end
        ST_DATA: begin
          store_r[count_r[IDX_W-1:0]] <= in_byte;
          sum_r   <= sum_nxt;
          count_r <= count_r + CNT_W'(1);
          if (count_r == CNT_W'(PAYLOAD_LEN - 1)) begin
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          skip_r <= skip_nxt;
          if (skip_nxt >= SKIP_W'(RESERVED_BYTES)) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Good or bad, the frame ends here and the parser starts over.
          state_r <= ST_HDR1;
          count_r <= '0;
          skip_r  <= '0;
          sum_r   <= '0;
        end
        default: begin
          state_r <= ST_HDR1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ifp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_queue: two-entry frame queue
// Holds good raw frames between the front and the back so each can stall
// on its own.
// ----------------------------------------------------------------------------
module ifp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ifp_pkg::q_ctrl_t    ctrl,
  input  ifp_pkg::raw_frame_t wr_data,
  output ifp_pkg::raw_frame_t rd_data,
  output logic                full,
  output logic                not_empty
);
  import ifp_pkg::*;

  raw_frame_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (ctrl.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (ctrl.pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/ifp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_back: axis remap and output register
// Applies the NED-to-ENU remap to the head frame and holds the result until
// the sink takes it.
// ----------------------------------------------------------------------------
module ifp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 q_not_empty,
  input  ifp_pkg::raw_frame_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ifp_pkg::imu_sample_t out_data
);
  import ifp_pkg::*;

  logic        enu_r;
  logic        valid_r;
  imu_sample_t data_r;
  imu_sample_t data_nxt;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Remap of the head frame.
  always_comb begin
    if (enu_r) begin
      data_nxt.angle_x     = q_data[W_PITCH];
      data_nxt.angle_y     = q_data[W_ROLL];
      data_nxt.angle_z     = neg_sat(q_data[W_YAW]);
      data_nxt.turn_rate_x = q_data[W_RX];
      data_nxt.turn_rate_y = neg_sat(q_data[W_RY]);
      data_nxt.turn_rate_z = neg_sat(q_data[W_RZ]);
      data_nxt.lin_accel_x = q_data[W_AX];
      data_nxt.lin_accel_y = neg_sat(q_data[W_AY]);
      data_nxt.lin_accel_z = neg_sat(q_data[W_AZ]);
    end else begin
      data_nxt.angle_x     = q_data[W_ROLL];
      data_nxt.angle_y     = q_data[W_PITCH];
      data_nxt.angle_z     = q_data[W_YAW];
      data_nxt.turn_rate_x = q_data[W_RX];
      data_nxt.turn_rate_y = q_data[W_RY];
      data_nxt.turn_rate_z = q_data[W_RZ];
      data_nxt.lin_accel_x = q_data[W_AX];
      data_nxt.lin_accel_y = q_data[W_AY];
      data_nxt.lin_accel_z = q_data[W_AZ];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enu_r <= 1'b0;
    end else if (cfg_we) begin
      enu_r <= cfg_wdata;
    end
  end

  // Output register: loads when empty or when the current result transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/core/imu_frame_parser.sv =====
`timescale 1ns / 1ps
// Path: after the transfer of the checksum byte, a result passes through the
// frame queue and then the output register.
// Throughput: one byte per cycle; the front stalls only on a checksum byte
// while the two-entry frame queue is full.
// Reset: synchronous, active low; clears the frame phase, counters, checksum,
// queue, output valid and the remap register.
// ----------------------------------------------------------------------------
// imu_frame_parser: IMU serial frame parser
// Finds header-framed packets in a byte stream, checks the checksum and
// emits nine signed 16-bit values, optionally remapped from NED to ENU.
// ----------------------------------------------------------------------------
module imu_frame_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  ifp_byte_if.sink     in_ch,
  ifp_imu_if.source    out_ch
);
  import ifp_pkg::*;

  raw_frame_t  push_data;
  raw_frame_t  head_data;
  q_ctrl_t     q_ctrl;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  imu_sample_t sample;

  // Front: frame sync and checksum.
  ifp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.byte_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // Queue controls gathered from both sides.
  assign q_ctrl = '{push: q_push, pop: q_pop};

  // Frame queue.
  ifp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .wr_data   (push_data),
    .rd_data   (head_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: remap and output register.
  ifp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_data      (head_data),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (sample)
  );

  // Result fields onto the output channel.
  assign out_ch.angle_x     = sample.angle_x;
  assign out_ch.angle_y     = sample.angle_y;
  assign out_ch.angle_z     = sample.angle_z;
  assign out_ch.turn_rate_x = sample.turn_rate_x;
  assign out_ch.turn_rate_y = sample.turn_rate_y;
  assign out_ch.turn_rate_z = sample.turn_rate_z;
  assign out_ch.lin_accel_x = sample.lin_accel_x;
  assign out_ch.lin_accel_y = sample.lin_accel_y;
  assign out_ch.lin_accel_z = sample.lin_accel_z;

endmodule
